// ===== hdl/pwsc_pkg.sv =====
package pwsc_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int IDX_W     = 32;
	localparam int PAGE_W    = 32;
	localparam int OFF_W     = 31;
	localparam int SLOT_W    = 3;
	localparam int LOG_W     = 5;
	localparam int BYTE_W    = 64;

	localparam logic [LOG_W-1:0] ITEM_SIZE_RST = 5'd0;
	localparam logic [LOG_W-1:0] PAGE_SIZE_RST = 5'd12;

	localparam logic REG_ITEM_SIZE = 1'b0;
	localparam logic REG_PAGE_SIZE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_XLATE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              act;
		logic              found;
		logic [PAGE_W-1:0] page;
	} srch_t;

endpackage

// ===== hdl/paged_window_slot_cache.sv =====
// Translates an element index into a page number and in-page offset and looks the page up in a
// fully associative set of SLOTS slots with round-robin replacement. One word is processed at a
// time: the index is scaled into a registered byte offset, the lookup walks the row of slot
// cells, and a missed page is installed as the result register is loaded. A new word is accepted
// in the cycle after the previous one has loaded the result register, even while that result
// still waits on the output, so a word is never taken before the previous one is through. The
// slots come out of reset empty, with no clearing pass. The user must write configuration through
// cfg_we, cfg_index and cfg_data only while idle; the block itself does not enforce this.
module paged_window_slot_cache
	import pwsc_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [LOG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [IDX_W-1:0]  element_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic [SLOT_W-1:0] slot_index,
	output logic [PAGE_W-1:0] page_number,
	output logic [OFF_W-1:0]  page_offset,
	output logic              evicted,
	output logic [PAGE_W-1:0] evicted_page
);

	localparam int SW = $clog2(SLOTS);

	logic [LOG_W-1:0]  item_log_q;
	logic [LOG_W-1:0]  page_log_q;
	state_t            state_q;
	state_t            state_d;
	logic [BYTE_W-1:0] byte_off_s1;
	logic [OFF_W-1:0]  offset_q;
	logic [BYTE_W-1:0] page_shift;
	logic [BYTE_W-1:0] off_mask;
	logic [PAGE_W-1:0] page_c;
	logic [SW-1:0]     victim_q;
	logic              fin_found_q;
	logic [SW-1:0]     fin_slot_q;
	logic [PAGE_W-1:0] fin_page_q;
	logic              out_valid_q;
	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PAGE_W-1:0] page_q;
	logic [OFF_W-1:0]  off_out_q;
	logic              evicted_q;
	logic [PAGE_W-1:0] ev_page_q;
	logic              accept;
	logic              inject;
	logic              finish;
	logic              install;
	logic              victim_valid;
	logic [PAGE_W-1:0] victim_page;

	srch_t             tok   [SLOTS+1];
	logic [SW-1:0]     tslot [SLOTS+1];
	logic [PAGE_W-1:0] cell_page  [SLOTS];
	logic              cell_valid [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_log_q <= ITEM_SIZE_RST;
			page_log_q <= PAGE_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ITEM_SIZE: item_log_q <= cfg_data;
				REG_PAGE_SIZE: page_log_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_XLATE;
			ST_XLATE:  state_d = ST_SEARCH;
			ST_SEARCH: if (tok[SLOTS].act) state_d = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		inject   = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_XLATE:  inject = 1'b1;
			ST_SEARCH: ;
			ST_FINISH: finish = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	assign accept  = in_valid && in_ready;
	assign install = finish && !fin_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_off_s1 <= BYTE_W'(element_index) << item_log_q;
		end
	end

	assign page_shift = byte_off_s1 >> page_log_q;
	assign page_c     = page_shift[PAGE_W-1:0];
	assign off_mask   = (BYTE_W'(1) << page_log_q) - BYTE_W'(1);

	always_ff @(posedge clk) begin
		if (inject) begin
			offset_q <= byte_off_s1[OFF_W-1:0] & off_mask[OFF_W-1:0];
		end
	end

	assign tok[0]   = '{act: inject, found: 1'b0, page: page_c};
	assign tslot[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		pwsc_cell #(
			.SW  (SW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up        (tok[i]),
			.up_slot   (tslot[i]),
			.down      (tok[i+1]),
			.down_slot (tslot[i+1]),
			.wr_en     (install && (victim_q == SW'(i))),
			.wr_page   (fin_page_q),
			.page      (cell_page[i]),
			.valid     (cell_valid[i])
		);
	end

	assign victim_valid = cell_valid[victim_q];
	assign victim_page  = cell_page[victim_q];

	always_ff @(posedge clk) begin
		if (state_q == ST_SEARCH && tok[SLOTS].act) begin
			fin_found_q <= tok[SLOTS].found;
			fin_slot_q  <= tslot[SLOTS];
			fin_page_q  <= tok[SLOTS].page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			victim_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (install) begin
				if (victim_q == SW'(SLOTS - 1)) begin
					victim_q <= '0;
				end else begin
					victim_q <= victim_q + SW'(1);
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q     <= fin_found_q;
			slot_q    <= fin_found_q ? SLOT_W'(fin_slot_q) : SLOT_W'(victim_q);
			page_q    <= fin_page_q;
			off_out_q <= offset_q;
			evicted_q <= !fin_found_q && victim_valid;
			ev_page_q <= (!fin_found_q && victim_valid) ? victim_page : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign slot_index   = slot_q;
	assign page_number  = page_q;
	assign page_offset  = off_out_q;
	assign evicted      = evicted_q;
	assign evicted_page = ev_page_q;

endmodule

// ===== hdl/pwsc_cell.sv =====
module pwsc_cell
	import pwsc_pkg::*;
#(
	parameter int SW  = 3,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srch_t             up,
	input  logic [SW-1:0]     up_slot,
	output srch_t             down,
	output logic [SW-1:0]     down_slot,
	input  logic              wr_en,
	input  logic [PAGE_W-1:0] wr_page,
	output logic [PAGE_W-1:0] page,
	output logic              valid
);

	logic [PAGE_W-1:0] page_q;
	logic              valid_q;
	srch_t             down_q;
	logic [SW-1:0]     down_slot_q;
	logic              match;

	assign match = up.act && !up.found && valid_q && (page_q == up.page);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q      <= '0;
			down_slot_q <= '0;
			valid_q     <= 1'b0;
		end else begin
			down_q.act  <= up.act;
			down_q.page <= up.page;
			if (match) begin
				down_q.found <= 1'b1;
				down_slot_q  <= SW'(IDX);
			end else begin
				down_q.found <= up.found;
				down_slot_q  <= up_slot;
			end
			if (wr_en) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_q <= wr_page;
		end
	end

	assign down      = down_q;
	assign down_slot = down_slot_q;
	assign page      = page_q;
	assign valid     = valid_q;

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import pwsc_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  offset;
		logic              evicted;
		logic [PAGE_W-1:0] evicted_page;
	} lookup_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_ITEM_SIZE;
	logic [LOG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [IDX_W-1:0]  element_index = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              hit;
	logic [SLOT_W-1:0] slot_index;
	logic [PAGE_W-1:0] page_number;
	logic [OFF_W-1:0]  page_offset;
	logic              evicted;
	logic [PAGE_W-1:0] evicted_page;

	logic [IDX_W-1:0]  pending_indices[$];
	lookup_t           expected_lookups[$];
	lookup_t           oldest;

	logic [LOG_W-1:0]  item_log2_m;
	logic [LOG_W-1:0]  page_log2_m;
	logic [PAGE_W-1:0] resident_page[SLOTS_DEF];
	logic              resident_valid[SLOTS_DEF];
	int                victim_m;

	bit                send_idle;
	bit                recv_idle;
	int                send_gap;
	int                recv_stall;
	int                cycles = 0;
	int                errors;
	int                lookups;
	int                hits_seen;
	int                evictions_seen;
	int                settings;

	logic [IDX_W-1:0]  index_pool[16];
	int                pool_n;

	paged_window_slot_cache u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_index(element_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.slot_index   (slot_index),
		.page_number  (page_number),
		.page_offset  (page_offset),
		.evicted      (evicted),
		.evicted_page (evicted_page)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic translate_and_fill(input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] byte_off;
		logic [BYTE_W-1:0] mask;
		lookup_t           r;
		int                slot;
		bit                found;
		byte_off = {32'b0, idx} << item_log2_m;
		mask = (64'd1 << page_log2_m) - 64'd1;
		r = '0;
		r.page = PAGE_W'(byte_off >> page_log2_m);
		r.offset = OFF_W'(byte_off & mask);
		found = 1'b0;
		slot = 0;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (!found && resident_valid[i] && resident_page[i] == r.page) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (!found) begin
			slot = victim_m;
			if (resident_valid[slot]) begin
				r.evicted = 1'b1;
				r.evicted_page = resident_page[slot];
				evictions_seen++;
			end
			resident_page[slot] = r.page;
			resident_valid[slot] = 1'b1;
			victim_m = (slot + 1) % SLOTS_DEF;
		end else begin
			hits_seen++;
		end
		r.hit = found;
		r.slot = SLOT_W'(slot);
		expected_lookups.push_back(r);
		lookups++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			element_index <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				translate_and_fill(element_index);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_indices.size() > 0) begin
					element_index <= pending_indices.pop_front();
					in_valid <= 1'b1;
					if (send_idle && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 12);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lookups.size() == 0) begin
					$display("%0t: result word with no expectation, expected none, actual page %h",
						$time, page_number);
					errors++;
				end else begin
					oldest = expected_lookups.pop_front();
					check_field("hit", 32'(oldest.hit), 32'(hit));
					check_field("slot_index", 32'(oldest.slot), 32'(slot_index));
					check_field("page_number", oldest.page, page_number);
					check_field("page_offset", 32'(oldest.offset), 32'(page_offset));
					check_field("evicted", 32'(oldest.evicted), 32'(evicted));
					check_field("evicted_page", oldest.evicted_page, evicted_page);
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ready <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 9) == 0) begin
				recv_stall <= $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic drain();
		@(negedge clk);
		while (pending_indices.size() > 0 || in_valid || expected_lookups.size() > 0)
			@(negedge clk);
	endtask

	task automatic set_sizes(input logic [LOG_W-1:0] item_log2, input logic [LOG_W-1:0] page_log2);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ITEM_SIZE;
		cfg_data <= item_log2;
		item_log2_m = item_log2;
		@(posedge clk);
		cfg_index <= REG_PAGE_SIZE;
		cfg_data <= page_log2;
		page_log2_m = page_log2;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		int unsigned span;
		logic [IDX_W-1:0] mask;
		logic [LOG_W-1:0] isz;
		logic [LOG_W-1:0] psz;
		item_log2_m = ITEM_SIZE_RST;
		page_log2_m = PAGE_SIZE_RST;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			resident_page[i] = '0;
			resident_valid[i] = 1'b0;
		end
		victim_m = 0;
		errors = 0;
		lookups = 0;
		hits_seen = 0;
		evictions_seen = 0;
		settings = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset sizes: hit, fill every slot, then wrap the victim pointer and evict resident pages.
		pending_indices.push_back(32'h0000_0000);
		pending_indices.push_back(32'h0000_0FFF);
		for (int k = 1; k < 8; k++)
			pending_indices.push_back(32'(k) << 12);
		pending_indices.push_back(32'h0000_8000);
		pending_indices.push_back(32'h0000_0000);
		drain();

		// One-byte items and pages; the all-ones page is an ordinary resident page.
		set_sizes(5'd0, 5'd0);
		pending_indices.push_back(32'hFFFF_FFFF);
		pending_indices.push_back(32'hFFFF_FFFF);
		pending_indices.push_back(32'h0000_0000);
		drain();
		set_sizes(5'd31, 5'd31);
		pending_indices.push_back(32'hFFFF_FFFF);
		pending_indices.push_back(32'h8000_0000);
		drain();
		set_sizes(5'd0, 5'd31);
		pending_indices.push_back(32'h7FFF_FFFF);
		pending_indices.push_back(32'hFFFF_FFFF);
		drain();
		set_sizes(5'd31, 5'd0);
		pending_indices.push_back(32'h0000_0001);
		pending_indices.push_back(32'hFFFF_FFFF);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					isz = 5'd0;
					psz = 5'd31;
				end
				1: begin
					isz = 5'd31;
					psz = 5'd31;
				end
				2: begin
					isz = 5'd31;
					psz = 5'd0;
				end
				3: begin
					isz = 5'd0;
					psz = 5'd0;
				end
				default: begin
					isz = LOG_W'($urandom_range(0, 31));
					if ($urandom_range(0, 1) == 0)
						psz = LOG_W'($urandom_range(0, 31));
					else
						psz = (int'(isz) + $urandom_range(0, 20) > 31) ? 5'd31
							: LOG_W'(int'(isz) + $urandom_range(0, 20));
				end
			endcase
			if (ph >= RANDOM_PHASES - 2) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end else begin
				send_idle = $urandom_range(0, 3) != 0;
				recv_idle = $urandom_range(0, 3) != 0;
			end
			set_sizes(isz, psz);
			span = (psz > isz) ? 32'(psz - isz) : 0;
			mask = (span >= 32) ? '1 : (32'd1 << span) - 32'd1;
			pool_n = $urandom_range(3, 14);
			for (int k = 0; k < pool_n; k++) begin
				case ($urandom_range(0, 7))
					0: index_pool[k] = '0;
					1: index_pool[k] = '1;
					default: index_pool[k] = $urandom;
				endcase
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0)
					pending_indices.push_back($urandom);
				else
					pending_indices.push_back(index_pool[$urandom_range(0, pool_n - 1)]
						^ ($urandom & mask));
			end
			drain();
		end

		repeat (24) @(posedge clk);
		$display("Checked %0d lookups across %0d size settings.", lookups, settings);
		$display("They gave %0d hits, %0d misses and %0d evictions.",
			hits_seen, lookups - hits_seen, evictions_seen);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
